/* design/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants of the crossfade pitch shifter.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int RATE_W               = 15;
    localparam int DEFAULT_BUFFER_DEPTH = 2048;
    localparam int READ_STEP            = 2;
    localparam int OUT_FIFO_DEPTH       = 4;

    localparam logic [RATE_W-1:0] FULL_SCALE = 15'h7FFF;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [RATE_W-1:0]   t_rate;

endpackage

/* design/cps_if.sv */
// ----------------------------------------------------------------------------
// cps_in_if / cps_out_if
// Valid/ready channels carrying input items and result samples.
// ----------------------------------------------------------------------------
interface cps_in_if;
    logic           valid;
    logic           ready;
    cps_pkg::t_rate   shift_rate;
    cps_pkg::t_sample sample_in;

    modport source (output valid, output shift_rate, output sample_in, input ready);
    modport sink   (input valid, input shift_rate, input sample_in, output ready);
endinterface

interface cps_out_if;
    logic           valid;
    logic           ready;
    cps_pkg::t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* design/crossfade_pitch_shifter_unit.sv */
// ----------------------------------------------------------------------------
// crossfade_pitch_shifter_unit
// Delay-line pitch shifter with two taps half a buffer apart and a
// triangular crossfade between them.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per transfer: shift_rate (phase step) and
//   sample_in. o_out carries one sample_out per accepted item, in order.
//   Throughput: one item per cycle while i_in.ready is high. The sample
//   buffer is a memory with one write and two read addresses per cycle;
//   the write of the new sample and both tap reads happen at the transfer
//   edge, so the memory does not limit the rate. A result is offered once
//   it has passed the tap read and product registers and the output queue
//   (tap read, multiply, sum and shift into the output queue).
//   Reset: pointers and phase clear, then a clearing pass writes zero to
//   every buffer entry, one per cycle; i_in.ready stays low during that
//   pass.
//   Stall: up to four items may be in flight or waiting in the four-entry
//   output queue; when the receiver holds o_out.ready low the queue fills
//   and i_in.ready drops until a result transfers. No result is lost.
// ----------------------------------------------------------------------------
module crossfade_pitch_shifter_unit #(
    parameter int BUFFER_DEPTH = cps_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cps_in_if.sink    i_in,
    cps_out_if.source o_out
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int VSHIFT  = 16 - AW;
    localparam int FD      = cps_pkg::OUT_FIFO_DEPTH;
    localparam int FAW     = $clog2(FD);
    localparam int CW      = $clog2(FD + 1);
    localparam logic [AW-1:0] HALF = AW'(BUFFER_DEPTH / 2);
    localparam logic [AW-1:0] STEP = AW'(cps_pkg::READ_STEP);
    localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

    // sample buffer
    cps_pkg::t_sample r_mem [BUFFER_DEPTH];

    // pointers and phase
    logic [AW-1:0]            r_wp, r_rp, n_wp, n_rp;
    logic [cps_pkg::RATE_W-1:0] r_acc, n_acc;
    logic [cps_pkg::RATE_W:0]   phase_sum;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // in-flight count (pipeline plus output queue)
    logic [CW-1:0] r_cnt;

    logic in_xfer, out_xfer;

    // memory port signals
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, rd_addr_a, rd_addr_b;
    cps_pkg::t_sample mem_wdata;
    cps_pkg::t_sample r_rd_a, r_rd_b;

    // weight
    logic [AW-1:0]              ptr_gap;
    logic [15:0]                vpos;
    logic [cps_pkg::RATE_W-1:0] weight;

    // stage 1: taps read
    logic                       r_s1_v;
    logic [cps_pkg::RATE_W-1:0] r_w1;
    cps_pkg::t_sample           r_smp1;
    logic                       r_fwd_a, r_fwd_b;
    cps_pkg::t_sample           tap_a, tap_b;
    logic signed [31:0]         mul_a, mul_b;

    // stage 2: products
    logic               r_s2_v;
    logic signed [31:0] r_prod_a, r_prod_b;
    logic signed [32:0] mix_sum;

    // output queue
    cps_pkg::t_sample r_fifo [FD];
    logic [FAW-1:0]   r_fwr, r_frd;
    logic [CW-1:0]    r_fill;

    // ------------------------------------------------------------------
    // Handshake: accept while the buffer is live and the queue has room
    // for everything already in flight.
    // ------------------------------------------------------------------
    assign i_in.ready = !r_clr_busy && (r_cnt < CW'(FD));
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;

    // ------------------------------------------------------------------
    // Pointer update: advance write pointer by one, read pointer by the
    // step on phase overflow.
    // ------------------------------------------------------------------
    always_comb begin
        n_wp      = r_wp + AW'(1);
        phase_sum = {1'b0, r_acc} + {1'b0, i_in.shift_rate};
        n_acc     = phase_sum[cps_pkg::RATE_W-1:0];
        n_rp      = phase_sum[cps_pkg::RATE_W] ? (r_rp + STEP) : r_rp;
    end

    // second tap sits half a buffer ahead: flip the top address bit
    assign rd_addr_a = n_rp;
    assign rd_addr_b = n_rp ^ HALF;

    // Triangular weight: distance scaled to 16 bits, folded at the midpoint.
    assign ptr_gap = n_wp - n_rp;
    assign vpos    = {ptr_gap, {VSHIFT{1'b0}}};
    assign weight  = vpos[15] ? ~vpos[14:0] : vpos[14:0];

    // Write side: the clearing pass owns the port until it finishes.
    assign mem_we    = r_clr_busy || in_xfer;
    assign mem_waddr = r_clr_busy ? r_clr_addr : n_wp;
    assign mem_wdata = r_clr_busy ? cps_pkg::t_sample'('0) : i_in.sample_in;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // ------------------------------------------------------------------
    // Control state: pointers, phase, clearing pass, counters.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_acc      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_fwr      <= '0;
            r_frd      <= '0;
            r_fill     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_xfer) begin
                r_wp  <= n_wp;
                r_rp  <= n_rp;
                r_acc <= n_acc;
            end
            r_cnt  <= r_cnt + CW'(in_xfer) - CW'(out_xfer);
            r_s1_v <= in_xfer;
            r_s2_v <= r_s1_v;
            if (r_s2_v) begin
                r_fwr <= r_fwr + FAW'(1);
            end
            if (out_xfer) begin
                r_frd <= r_frd + FAW'(1);
            end
            r_fill <= r_fill + CW'(r_s2_v) - CW'(out_xfer);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold weight and fresh sample; forward the fresh sample when
    // a tap reads the entry written in the same cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_w1    <= weight;
        r_smp1  <= i_in.sample_in;
        r_fwd_a <= (rd_addr_a == n_wp);
        r_fwd_b <= (rd_addr_b == n_wp);
    end

    assign tap_a = r_fwd_a ? r_smp1 : r_rd_a;
    assign tap_b = r_fwd_b ? r_smp1 : r_rd_b;
    assign mul_a = tap_a * $signed({1'b0, r_w1});
    assign mul_b = tap_b * $signed({1'b0, cps_pkg::FULL_SCALE - r_w1});

    // Stage 2: register products.
    always_ff @(posedge i_clk) begin
        r_prod_a <= mul_a;
        r_prod_b <= mul_b;
    end

    // Stage 3: sum, floor shift by 15, push into the output queue.
    assign mix_sum = {r_prod_a[31], r_prod_a} + {r_prod_b[31], r_prod_b};

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_fifo[r_fwr] <= mix_sum[30:15];
        end
    end

    assign o_out.valid      = (r_fill != '0);
    assign o_out.sample_out = r_fifo[r_frd];

endmodule

/* design/cps_checker.sv */
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks on the crossfade pitch shifter, bound to the top level.
// ----------------------------------------------------------------------------
module cps_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input cps_pkg::t_sample i_sample_out
);

    localparam int FD = cps_pkg::OUT_FIFO_DEPTH;
    localparam int CW = $clog2(FD + 1);

    logic [CW-1:0] r_pend;

    // track accepted items whose results have not yet transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + CW'(i_in_valid && i_in_ready)
                             - CW'(i_out_valid && i_out_ready);
        end
    end

    // the buffer clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("input accepted during buffer clearing");

    // no result without an accepted item behind it
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != '0))
        else $error("result offered with nothing pending");

    // queue capacity bounds the items in flight
    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == CW'(FD)) |-> !i_in_ready)
        else $error("input accepted with output queue full");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sample_out)))
        else $error("stalled result changed");

endmodule

bind crossfade_pitch_shifter_unit cps_checker u_cps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_sample_out (o_out.sample_out)
);
